// ===== rtl/smt_pkg.sv =====
// Shared types and constants for the sliding median time block.
// No dependencies; every other file imports this package.
package smt_pkg;

    localparam int unsigned WINDOW_DEFAULT = 11;
    localparam int unsigned TIME_W         = 32;
    localparam int unsigned USED_W         = 4;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_PICK = 3'b100
    } smt_state_t;

    typedef struct packed {
        logic accept;
        logic step;
        logic pick;
        logic load;
    } smt_ctl_t;

endpackage

// ===== rtl/smt_rank_bank.sv =====
// Rank lanes: compare one broadcast stored time per cycle against every lane,
// count ranks, then pick the lane whose rank equals the middle index.
// Depends on smt_pkg.
module smt_rank_bank
    import smt_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEFAULT,
    parameter int unsigned IDX_W  = 4,
    parameter int unsigned CNT_W  = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  smt_ctl_t          ctl,
    input  logic [IDX_W-1:0]  scan_idx,
    input  logic [CNT_W-1:0]  fill,
    input  logic [TIME_W-1:0] entries [WINDOW],
    output logic [TIME_W-1:0] median
);

    logic [TIME_W-1:0] bval;
    logic [IDX_W-1:0]  mid_rank;
    logic [IDX_W-1:0]  rank_reg [WINDOW];
    logic [WINDOW-1:0] lane_valid;
    logic [WINDOW-1:0] match;

    assign bval     = entries[scan_idx];
    assign mid_rank = IDX_W'(fill >> 1);

    for (genvar i = 0; i < WINDOW; i++) begin : g_lane
        logic ahead;

        assign lane_valid[i] = (CNT_W'(i) < fill);
        // ties break on slot index so every kept value gets a distinct rank
        assign ahead = (bval < entries[i]) ||
                       ((bval == entries[i]) && (scan_idx < IDX_W'(i)));
        assign match[i] = lane_valid[i] && (rank_reg[i] == mid_rank);

        always_ff @(posedge clk)
        begin
            if (ctl.accept)
            begin
                rank_reg[i] <= '0;
            end
            else if (ctl.step && lane_valid[i] && ahead)
            begin
                rank_reg[i] <= rank_reg[i] + 1'b1;
            end
        end
    end

    always_comb
    begin
        median = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            if (match[i])
            begin
                median = median | entries[i];
            end
        end
    end

    a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pick |-> $onehot(match))
        else $error("rank bank: median lane not unique");

endmodule

// ===== rtl/smt_ctrl.sv =====
// Sequencer: accept a beat, step the scan index over the kept entries,
// then hand the picked median to the output register.
// Depends on smt_pkg.
module smt_ctrl
    import smt_pkg::*;
#(
    parameter int unsigned IDX_W = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             out_free,
    input  logic [IDX_W-1:0] last_idx,
    output logic             busy,
    output logic [IDX_W-1:0] scan_idx,
    output smt_ctl_t         ctl
);

    smt_state_t       state_reg;
    smt_state_t       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.accept = 1'b1;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctl.step = 1'b1;
                if (idx_reg == last_idx)
                begin
                    state_next = ST_PICK;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_PICK:
            begin
                ctl.pick = 1'b1;
                if (out_free)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign scan_idx = idx_reg;

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg <= last_idx))
        else $error("ctrl: scan index past last kept entry");

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.accept |=> ((state_reg == ST_SCAN) && (idx_reg == '0)))
        else $error("ctrl: accepted beat did not start a scan");

endmodule

// ===== rtl/sliding_median_time_core.sv =====
// Top level of the sliding median time block: window store, fill and slot
// counters, output register. Depends on smt_pkg, smt_ctrl, smt_rank_bank.
//
//  channel   dir  handshake                  payload
//  time      in   time_valid / time_stall    block_time[31:0]
//  median    out  median_valid / median_stall median_time[31:0], values_used[3:0]
//
// Each time beat is stored in the cycle it is accepted; then each of the n kept
// timestamps (n counted after the new beat is stored) is broadcast in turn to
// the rank lanes, and then the middle rank is picked into the output register.
// time_stall is high from acceptance until the median is loaded; a median
// waiting under median_stall holds the pick cycle until the register frees.
// Reset clears the fill count, write slot and sequencer; the window store
// is not cleared, since the fill count keeps unwritten slots out of the scan.
module sliding_median_time_core
    import smt_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              time_valid,
    output logic              time_stall,
    input  logic [TIME_W-1:0] block_time,
    output logic              median_valid,
    input  logic              median_stall,
    output logic [TIME_W-1:0] median_time,
    output logic [USED_W-1:0] values_used
);

    localparam int unsigned CNT_W = $clog2(WINDOW + 1);
    localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    smt_ctl_t          ctl;
    logic              busy;
    logic [IDX_W-1:0]  scan_idx;
    logic [IDX_W-1:0]  last_idx;
    logic              out_free;
    logic [TIME_W-1:0] median;

    logic [TIME_W-1:0] time_window_reg [WINDOW];
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [IDX_W-1:0]  write_slot_reg;
    logic [IDX_W-1:0]  write_slot_next;

    logic              median_valid_reg;
    logic [TIME_W-1:0] median_time_reg;
    logic [USED_W-1:0] values_used_reg;

    // saturate the fill count at the window size, wrap the write slot
    assign fill_next       = (fill_reg == CNT_W'(WINDOW)) ? fill_reg : fill_reg + 1'b1;
    assign write_slot_next = (write_slot_reg == IDX_W'(WINDOW - 1)) ? '0
                                                                     : write_slot_reg + 1'b1;
    // fill is at least one whenever the scan runs
    assign last_idx        = IDX_W'(fill_reg - 1'b1);
    assign out_free        = !median_valid_reg || !median_stall;

    smt_ctrl #(
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (time_valid),
        .out_free (out_free),
        .last_idx (last_idx),
        .busy     (busy),
        .scan_idx (scan_idx),
        .ctl      (ctl)
    );

    smt_rank_bank #(
        .WINDOW (WINDOW),
        .IDX_W  (IDX_W),
        .CNT_W  (CNT_W)
    ) u_rank_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .scan_idx (scan_idx),
        .fill     (fill_reg),
        .entries  (time_window_reg),
        .median   (median)
    );

    // overwrite the oldest slot with the new beat
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            time_window_reg[write_slot_reg] <= block_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            write_slot_reg <= '0;
        end
        else if (ctl.accept)
        begin
            fill_reg       <= fill_next;
            write_slot_reg <= write_slot_next;
        end
    end

    // output register: hold while stalled, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            median_valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            median_valid_reg <= 1'b1;
        end
        else if (!median_stall)
        begin
            median_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            median_time_reg <= median;
            values_used_reg <= USED_W'(fill_reg);
        end
    end

    assign time_stall   = busy;
    assign median_valid = median_valid_reg;
    assign median_time  = median_time_reg;
    assign values_used  = values_used_reg;

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> ((fill_reg != '0) && (fill_reg <= CNT_W'(WINDOW))))
        else $error("core: fill count out of range while busy");

endmodule

// ===== tb/tb_sliding_median_time_core.sv =====
// Self-checking bench for sliding_median_time_core: timestamp beats in, medians out.
// Depends on smt_pkg and the sliding_median_time_core RTL; reads no files.
module tb_sliding_median_time_core
    import smt_pkg::*;
;

    localparam int unsigned WIN        = WINDOW_DEFAULT;
    localparam int unsigned RAND_BEATS = 1100;
    localparam int unsigned DRAIN_CYC  = 40;

    // Running-median predictor plus the queue of medians still owed by the block.
    // It keeps its own copy of the window and its counters.
    class median_scoreboard;
        typedef struct {
            logic [TIME_W-1:0] med;
            logic [USED_W-1:0] used;
        } median_beat_t;

        logic [TIME_W-1:0] kept_times [WIN];
        int unsigned       kept_cnt;
        int unsigned       next_slot;
        median_beat_t      owed_q [$];
        int unsigned       errors;

        function new();
            kept_cnt  = 0;
            next_slot = 0;
            errors    = 0;
        endfunction

        // Store an accepted timestamp and queue the median it must produce.
        function void note_time(logic [TIME_W-1:0] t);
            logic [TIME_W-1:0] ranked [WIN];
            logic [TIME_W-1:0] v;
            median_beat_t      exp_beat;
            int unsigned       i;
            int unsigned       j;
            kept_times[next_slot] = t;
            next_slot = (next_slot + 1 == WIN) ? 0 : next_slot + 1;
            if (kept_cnt < WIN)
                kept_cnt++;
            // insertion sort; duplicates keep separate ranks
            for (i = 0; i < kept_cnt; i++)
            begin
                v = kept_times[i];
                j = i;
                while (j > 0 && ranked[j-1] > v)
                begin
                    ranked[j] = ranked[j-1];
                    j--;
                end
                ranked[j] = v;
            end
            exp_beat.med  = ranked[kept_cnt / 2];
            exp_beat.used = USED_W'(kept_cnt);
            owed_q = {owed_q, exp_beat};
        endfunction

        function void check_median(logic [TIME_W-1:0] med, logic [USED_W-1:0] used);
            median_beat_t exp_beat;
            if (owed_q.size() == 0)
            begin
                $error("median beat with no timestamp pending: median_time=%0d values_used=%0d",
                       med, used);
                errors++;
                return;
            end
            exp_beat = owed_q.pop_front();
            if (med !== exp_beat.med)
            begin
                $error("median_time mismatch: expected %0d, got %0d", exp_beat.med, med);
                errors++;
            end
            if (used !== exp_beat.used)
            begin
                $error("values_used mismatch: expected %0d, got %0d", exp_beat.used, used);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              time_valid;
    logic              time_stall;
    logic [TIME_W-1:0] block_time;
    logic              median_valid;
    logic              median_stall;
    logic [TIME_W-1:0] median_time;
    logic [USED_W-1:0] values_used;

    median_scoreboard sb = new();

    // Phase knobs: when set, the matching side never idles.
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;

    sliding_median_time_core #(.WINDOW(WIN)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .time_valid   (time_valid),
        .time_stall   (time_stall),
        .block_time   (block_time),
        .median_valid (median_valid),
        .median_stall (median_stall),
        .median_time  (median_time),
        .values_used  (values_used)
    );

    // 10-unit clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Pick an idle gap: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Present one timestamp beat at the falling edge and hold it until taken.
    // A zero gap keeps valid high straight into the next beat.
    task automatic send_time(input logic [TIME_W-1:0] t);
        int unsigned gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            time_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        time_valid <= 1'b1;
        block_time <= t;
        // accepted at the first rising edge that sees stall low
        @(posedge clk);
        while (time_stall)
            @(posedge clk);
        sb.note_time(t);
    endtask

    // Drop valid and hold until every owed median has come back.
    task automatic wait_drained();
        @(negedge clk);
        time_valid <= 1'b0;
        while (sb.owed_q.size() != 0)
            @(posedge clk);
    endtask

    // Receiver back-pressure: runs of open cycles broken by stalls, mostly
    // short, sometimes long; none at all while rx_quiet is set.
    initial
    begin
        int unsigned open_cyc;
        int unsigned stall_cyc;
        median_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            open_cyc = $urandom_range(0, 12);
            repeat (open_cyc + 1)
            begin
                @(negedge clk);
                median_stall <= 1'b0;
            end
            if ($urandom_range(0, 9) == 0)
                stall_cyc = $urandom_range(15, 60);
            else
                stall_cyc = $urandom_range(1, 3);
            repeat (stall_cyc)
            begin
                @(negedge clk);
                median_stall <= !rx_quiet;
            end
        end
    end

    // Check every median beat taken at a rising edge.
    always @(posedge clk)
    begin
        if (rst_n && median_valid && !median_stall)
            sb.check_median(median_time, values_used);
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // Main sequence: reset, directed beats, random phases, drain, verdict.
    initial
    begin
        logic [TIME_W-1:0] directed_times [$];
        logic [TIME_W-1:0] chain_time;
        logic [TIME_W-1:0] t;
        int unsigned       sent;
        int unsigned       phase_len;
        int unsigned       mode;
        int unsigned       k;

        time_valid = 1'b0;
        block_time = '0;
        rst_n      = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: warm-up through every count 1..11, extremes, duplicates,
        // then past a full window so the oldest entries get overwritten.
        directed_times = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                           32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0005, 32'h0000_0005,
                           32'h0000_0005, 32'h0000_0001, 32'hFFFF_FFFE, 32'h0000_0005,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                           32'h6000_0000, 32'h5FFF_FFFF, 32'h6000_0001, 32'hAAAA_AAAA,
                           32'h5555_5555};
        tx_quiet = 1'b1;
        foreach (directed_times[i])
            send_time(directed_times[i]);
        tx_quiet = 1'b0;

        // Hold the sender until the block has answered everything.
        wait_drained();

        // Random phases. Most look like a real chain: slowly rising times with
        // jitter and small steps back; the rest is full-range noise, heavy
        // duplicates and runs across the 32-bit wrap.
        chain_time = $urandom_range(0, 1_000_000);
        sent       = 0;
        while (sent < RAND_BEATS)
        begin
            phase_len = $urandom_range(15, 60);
            mode      = $urandom_range(0, 9);
            tx_quiet  = ($urandom_range(0, 4) == 0);
            rx_quiet  = ($urandom_range(0, 4) == 0);
            if (mode == 8)
                chain_time = 32'hFFFF_FFFF - $urandom_range(0, 20000);
            for (k = 0; k < phase_len && sent < RAND_BEATS; k++)
            begin
                if (mode < 6 || mode == 8)
                begin
                    if ($urandom_range(0, 7) == 0)
                        chain_time = chain_time - $urandom_range(0, 900);
                    else
                        chain_time = chain_time + $urandom_range(0, 1200);
                    t = chain_time;
                end
                else if (mode == 6)
                begin
                    t = $urandom;
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       t = 32'h0000_0000;
                        1:       t = 32'hFFFF_FFFF;
                        2:       t = 32'h8000_0000;
                        default: t = chain_time;
                    endcase
                end
                send_time(t);
                sent++;
            end
            // now and then let everything drain mid-run
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        // Drain, then give the sequencer time to show any stray beat.
        wait_drained();
        repeat (DRAIN_CYC) @(posedge clk);

        if (sb.errors == 0 && sb.owed_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
